>>> hw/rtl/range_bin_confirm_hold_macros.svh
// Assertion macros for the range bin confirmation filter.
`ifndef RANGE_BIN_CONFIRM_HOLD_MACROS_SVH
`define RANGE_BIN_CONFIRM_HOLD_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define RBCH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define RBCH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/rbch_pkg.sv
// Shared types and constants of the range bin confirmation filter.
package rbch_pkg;

  localparam int RANGE_W  = 16;
  localparam int ENTRY_W  = RANGE_W + 1;
  localparam int TIME_W   = 32;
  localparam int BIN_W    = 10;
  localparam int COUNT_W  = 11;
  localparam int LEN_W    = 7;
  localparam int REC_W    = 1 + TIME_W + RANGE_W;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  localparam logic [1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [1:0] REG_NEEDED_HITS   = 2'd1;
  localparam logic [1:0] REG_TOLERANCE     = 2'd2;
  localparam logic [1:0] REG_HOLD_TIME     = 2'd3;

  localparam logic CMD_UPDATE = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef struct packed {
    logic [LEN_W-1:0]   len;
    logic [RANGE_W-1:0] tol;
  } win_cfg_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_CMP   = 6'b001000,
    S_CNT   = 6'b010000,
    S_REND  = 6'b100000
  } state_e;

endpackage

>>> hw/rtl/rbch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rbch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> hw/rtl/rbch_window.sv
// Window row update and per-entry tolerance match for one bin.
module rbch_window
  import rbch_pkg::*;
#(
  parameter int MAX_WINDOW = 32,
  parameter int SW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1
) (
  input  logic [MAX_WINDOW*ENTRY_W-1:0] row_i,
  input  logic [SW-1:0]                 slot_i,
  input  logic                          present_i,
  input  logic [RANGE_W-1:0]            range_i,
  input  win_cfg_t                      cfg_i,
  output logic [MAX_WINDOW*ENTRY_W-1:0] row_o,
  output logic [MAX_WINDOW-1:0]         match_o
);

  logic [ENTRY_W-1:0] new_entry;

  assign new_entry = present_i ? {1'b1, range_i} : '0;

  for (genvar f = 0; f < MAX_WINDOW; f++) begin : g_ent
    logic [ENTRY_W-1:0] ent;
    logic [RANGE_W-1:0] diff;

    assign ent = (slot_i == SW'(f)) ? new_entry : row_i[f*ENTRY_W +: ENTRY_W];
    assign diff = (ent[RANGE_W-1:0] > range_i) ? (ent[RANGE_W-1:0] - range_i)
                                                : (range_i - ent[RANGE_W-1:0]);
    assign row_o[f*ENTRY_W +: ENTRY_W] = ent;
    assign match_o[f] = (LEN_W'(f) < cfg_i.len) && ent[RANGE_W] && (diff <= cfg_i.tol);
  end

endmodule

>>> hw/rtl/range_bin_confirm_hold.sv
// Top level of the range bin confirmation filter.
//
// One range bin per input transfer on s_axis (tuser: 0 update, 1 query;
// tlast: last bin of the run). One result per input on m_axis, in order.
// Per bin, a window row (all frames of the bin in one memory word) and a
// held-range record live in two synchronous RAMs indexed by bin.
// An update of a new frame steps through accept, read, read-modify-write
// of the window row, match count and render; a query or a repeat frame
// skips the match count and leaves the row unwritten, and a bin at or
// past NUM_BINS skips both. One item is in flight at a time. The output
// register lets the next item be taken while a result waits; a stalled
// receiver holds the block in its render step, nothing is lost. Reset
// starts a clearing pass over all NUM_BINS entries of both RAMs with
// s_axis_tready low; an update run whose time is earlier than the last
// frame runs the same pass before its first bin. Configuration is written
// through cfg_we_i, cfg_index_i and cfg_data_i; the user must write it
// only while no item is in flight, the block does not enforce this.
module range_bin_confirm_hold
  import rbch_pkg::*;
#(
  parameter int NUM_BINS   = 1024,
  parameter int MAX_WINDOW = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // bin_index[9:0], range_mm[25:10], range_present[26], now_ms[58:27]
  input  logic [63:0] s_axis_tdata,
  // cmd[0]
  input  logic [0:0]  s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_bin[9:0], held_range_mm[25:10], held_valid[26], age_ms[58:27],
  // valid_so_far[69:59]
  output logic [71:0] m_axis_tdata,
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  localparam int AW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int SW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ROW_W = MAX_WINDOW * ENTRY_W;
  localparam int BCMP_W = 13;

  state_e state_q;

  logic [5:0]         wlen_q;
  logic [5:0]         need_q;
  logic [RANGE_W-1:0] tol_q;
  logic [TIME_W-1:0]  hold_q;

  logic               cmd_q, pres_q, last_q, bin_ok_q;
  logic [BIN_W-1:0]   bin_q;
  logic [RANGE_W-1:0] range_q;
  logic [TIME_W-1:0]  now_q;

  logic               rflag_q;
  logic [RANGE_W-1:0] rrange_q;
  logic [TIME_W-1:0]  rtime_q;
  logic [MAX_WINDOW-1:0] match_q;

  logic [SW-1:0]      wslot_q;
  logic [TIME_W-1:0]  prior_q;
  logic               have_prior_q, open_q, repeat_q, pend_q;
  logic [COUNT_W-1:0] vcnt_q;
  logic [AW-1:0]      clr_q;

  logic               out_valid_q, out_hv_q, out_last_q;
  logic [BIN_W-1:0]   out_bin_q;
  logic [RANGE_W-1:0] out_hr_q;
  logic [TIME_W-1:0]  out_age_q;
  logic [COUNT_W-1:0] out_vsf_q;

  logic [BIN_W-1:0]   in_bin;
  logic [RANGE_W-1:0] in_range;
  logic               in_pres;
  logic [TIME_W-1:0]  in_now;
  logic               accept, start, in_repeat, in_wipe;

  logic [LEN_W-1:0]   eff_len;
  logic [SW-1:0]      slot;
  logic [SW-1:0]      slot_next;
  win_cfg_t           wcfg;

  logic [ROW_W-1:0]   row_rdata, row_new, row_wdata;
  logic [MAX_WINDOW-1:0] match;
  logic [REC_W-1:0]   rec_rdata, rec_wdata;
  logic               row_we, rec_we, rd_en;
  logic [AW-1:0]      waddr, baddr;

  logic               upd, out_free, expired, valid_now;
  logic [TIME_W-1:0]  age;
  logic [LEN_W-1:0]   hits;
  logic [COUNT_W-1:0] vcnt_next;

  assign in_bin   = s_axis_tdata[9:0];
  assign in_range = s_axis_tdata[25:10];
  assign in_pres  = s_axis_tdata[26];
  assign in_now   = s_axis_tdata[58:27];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign start         = !open_q;
  assign in_repeat     = (s_axis_tuser[0] == CMD_QUERY) || (have_prior_q && (in_now == prior_q));
  assign in_wipe       = start && (s_axis_tuser[0] == CMD_UPDATE) && have_prior_q &&
                         (in_now < prior_q);

  always_comb begin
    if (wlen_q == 6'd0) begin
      eff_len = LEN_W'(1);
    end else if (LEN_W'(wlen_q) > LEN_W'(MAX_WINDOW)) begin
      eff_len = LEN_W'(MAX_WINDOW);
    end else begin
      eff_len = LEN_W'(wlen_q);
    end
  end

  assign slot      = (LEN_W'(wslot_q) < eff_len) ? wslot_q : '0;
  assign slot_next = ((LEN_W'(slot) + LEN_W'(1)) >= eff_len) ? '0 : SW'(LEN_W'(slot) + LEN_W'(1));
  assign wcfg      = '{len: eff_len, tol: tol_q};

  assign upd      = (cmd_q == CMD_UPDATE) && !repeat_q;
  assign out_free = !out_valid_q || m_axis_tready;
  assign age      = now_q - rtime_q;
  assign expired  = (now_q < rtime_q) || (age > hold_q);
  assign valid_now = bin_ok_q && rflag_q && !expired;
  assign hits     = LEN_W'($countones(match_q));
  assign vcnt_next = (valid_now && (vcnt_q != COUNT_MAX)) ? vcnt_q + 1'b1 : vcnt_q;

  assign baddr  = AW'(bin_q);
  assign rd_en  = (state_q == S_RD) && bin_ok_q;
  assign row_we = (state_q == S_CLEAR) || ((state_q == S_CMP) && upd);
  assign rec_we = (state_q == S_CLEAR) || ((state_q == S_REND) && out_free && bin_ok_q);
  assign waddr  = (state_q == S_CLEAR) ? clr_q : baddr;
  assign row_wdata = (state_q == S_CLEAR) ? '0 : row_new;
  assign rec_wdata = (state_q == S_CLEAR) ? '0 : {valid_now, rtime_q, rrange_q};

  rbch_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .row_i     (row_rdata),
    .slot_i    (slot),
    .present_i (pres_q),
    .range_i   (range_q),
    .cfg_i     (wcfg),
    .row_o     (row_new),
    .match_o   (match)
  );

  rbch_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_BINS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (waddr),
    .wdata_i (row_wdata),
    .re_i    (rd_en),
    .raddr_i (baddr),
    .rdata_o (row_rdata)
  );

  rbch_ram #(
    .WIDTH (REC_W),
    .DEPTH (NUM_BINS)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (waddr),
    .wdata_i (rec_wdata),
    .re_i    (rd_en),
    .raddr_i (baddr),
    .rdata_o (rec_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= 6'd5;
      need_q <= 6'd3;
      tol_q  <= 16'd100;
      hold_q <= 32'd500;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_WINDOW_LENGTH: wlen_q <= cfg_data_i[5:0];
        REG_NEEDED_HITS:   need_q <= cfg_data_i[5:0];
        REG_TOLERANCE:     tol_q  <= cfg_data_i[15:0];
        REG_HOLD_TIME:     hold_q <= cfg_data_i;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= s_axis_tuser[0];
      bin_q    <= in_bin;
      range_q  <= in_range;
      pres_q   <= in_pres;
      now_q    <= in_now;
      last_q   <= s_axis_tlast;
      bin_ok_q <= BCMP_W'(in_bin) < BCMP_W'(NUM_BINS);
    end
    case (state_q)
      S_RD: begin
        rflag_q <= 1'b0;
      end
      S_CMP: begin
        rflag_q  <= rec_rdata[REC_W-1];
        rtime_q  <= rec_rdata[RANGE_W +: TIME_W];
        rrange_q <= rec_rdata[RANGE_W-1:0];
        match_q  <= match;
      end
      S_CNT: begin
        if (pres_q && (hits >= LEN_W'(need_q))) begin
          rflag_q  <= 1'b1;
          rtime_q  <= now_q;
          rrange_q <= range_q;
        end
      end
      default: ;
    endcase
    if ((state_q == S_REND) && out_free) begin
      out_bin_q <= bin_q;
      out_hv_q  <= valid_now;
      out_hr_q  <= valid_now ? rrange_q : '0;
      out_age_q <= valid_now ? age : '0;
      out_vsf_q <= vcnt_next;
      out_last_q <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      pend_q       <= 1'b0;
      wslot_q      <= '0;
      prior_q      <= '0;
      have_prior_q <= 1'b0;
      open_q       <= 1'b0;
      repeat_q     <= 1'b0;
      vcnt_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          if (clr_q == AW'(NUM_BINS - 1)) begin
            clr_q   <= '0;
            pend_q  <= 1'b0;
            state_q <= pend_q ? S_RD : S_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_RD;
            if (start) begin
              open_q   <= 1'b1;
              vcnt_q   <= '0;
              repeat_q <= in_repeat;
              if (!in_repeat) begin
                prior_q      <= in_now;
                have_prior_q <= 1'b1;
              end
              if (in_wipe) begin
                wslot_q <= '0;
                pend_q  <= 1'b1;
                state_q <= S_CLEAR;
              end
            end
          end
        end
        S_RD: begin
          state_q <= bin_ok_q ? S_CMP : S_REND;
        end
        S_CMP: begin
          state_q <= upd ? S_CNT : S_REND;
        end
        S_CNT: begin
          state_q <= S_REND;
        end
        S_REND: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            vcnt_q      <= vcnt_next;
            state_q     <= S_IDLE;
            if (last_q) begin
              if (!repeat_q) begin
                wslot_q <= slot_next;
              end
              open_q   <= 1'b0;
              repeat_q <= 1'b0;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (m_axis_tready && !((state_q == S_REND) && out_free)) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_vsf_q, out_age_q, out_hv_q, out_hr_q, out_bin_q};

`include "range_bin_confirm_hold_macros.svh"

  `RBCH_ASSERT_NOW(a_row_write_state, row_we, (state_q == S_CLEAR) || (state_q == S_CMP), "window row written outside clear or compare")
  `RBCH_ASSERT_NOW(a_invalid_zero, out_valid_q && !out_hv_q, (out_hr_q == '0) && (out_age_q == '0), "invalid result carries range or age")
  `RBCH_ASSERT_NEXT(a_accept_busy, accept, state_q != S_IDLE, "block still idle after taking a transfer")

endmodule
